>>> rtl/core/mmr_pkg.sv
// Shared types, constants and helpers for the mailbox message reassembler.
package mmr_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LANES     = 4;
    localparam int unsigned LEN_W     = 8;
    localparam int unsigned CHUNK_W   = 5;
    localparam int unsigned IN_DATA_W = 32;
    localparam int unsigned OUT_DATA_W = 56;
    localparam logic [6:0] SIZE_MASK  = 7'h7F;
    localparam logic [7:0] FIRST_FRAME = 8'h01;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_STREAM
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic load_incomplete;
        logic load_chunk;
        logic advance;
    } ctrl_t;

    // floor(v / 3) for a 7-bit value, by reciprocal multiply
    function automatic logic [5:0] div3_7(input logic [6:0] v);
        logic [12:0] prod;
        prod = 13'(v) * 13'd43;
        return prod[12:7];
    endfunction

endpackage

>>> rtl/core/mailbox_message_reassembler_unit.sv
// Mailbox message reassembler: frame decode, lane-split payload store and chunk readback.
// A request passes the evaluate state before its incomplete status enters the output register;
// a completed message passes the evaluate state and the stream state (store read register)
// before its first chunk is loaded. A new request is taken only in idle, once the previous
// one is done; readback is one store row (four bytes) per cycle while the output is free.
// Reset (asynchronous, active low) clears the state, frame counters, length, id, chunk index
// and output valid; the payload store is not cleared and no clearing pass is needed.
module mailbox_message_reassembler_unit #(
    parameter int unsigned PAYLOAD_DEPTH = 128
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // head_byte, second_byte, third_byte, fourth_byte
    input  logic [mmr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // message_id, message_length, chunk_number, chunk_byte_a, chunk_byte_b,
    // chunk_byte_c, chunk_byte_d, zero pad
    output logic [mmr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // complete
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast
);
    import mmr_pkg::*;

    localparam int unsigned ROWS  = (PAYLOAD_DEPTH + 3) / 4;
    localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(PAYLOAD_DEPTH);

    state_t state_reg, state_next;
    ctrl_t  ctrl;

    logic [LEN_W-1:0]   wp_reg, wp_next;
    logic [BYTE_W-1:0]  id_reg, id_next;
    logic [7:0]         exp_reg, exp_next;
    logic [7:0]         rcv_reg, rcv_next;
    logic [CHUNK_W-1:0] k_reg, k_next;

    logic in_acc;
    logic out_free;
    logic is_start;
    logic [6:0] size;
    logic [1:0] n_cand;
    logic [LEN_W-1:0] base;
    logic [LEN_W-1:0] pos;
    logic [BYTE_W-1:0] cand [3];

    logic [LANES-1:0] lane_we;
    logic [BYTE_W-1:0] lane_wdata [LANES];
    logic [ROW_W-1:0]  lane_wrow  [LANES];
    logic [ROW_W-1:0]  rd_row;
    logic [BYTE_W-1:0] rd_data_reg [LANES];

    logic [CHUNK_W-1:0] last_k;
    logic [LEN_W-1:0]   lane_pos [LANES];
    logic [BYTE_W-1:0]  chunk_byte [LANES];

    logic               out_valid_reg;
    logic               out_complete_reg;
    logic               out_last_reg;
    logic [BYTE_W-1:0]  out_id_reg;
    logic [LEN_W-1:0]   out_len_reg;
    logic [CHUNK_W-1:0] out_chunk_reg;
    logic [BYTE_W-1:0]  out_byte_reg [LANES];

    assign in_acc   = s_axis_tvalid & s_axis_tready;
    assign out_free = ~out_valid_reg | m_axis_tready;

    // frame decode, byte placement and frame counting
    always_comb
    begin
        is_start = ~s_axis_tdata[7];
        size     = s_axis_tdata[6:0] & SIZE_MASK;
        if (is_start)
        begin
            base    = '0;
            n_cand  = (size > 7'd1) ? 2'd2 : ((size > 7'd0) ? 2'd1 : 2'd0);
            cand[0] = s_axis_tdata[23:16];
            cand[1] = s_axis_tdata[31:24];
            cand[2] = '0;
        end
        else
        begin
            base    = wp_reg;
            n_cand  = 2'd3;
            cand[0] = s_axis_tdata[15:8];
            cand[1] = s_axis_tdata[23:16];
            cand[2] = s_axis_tdata[31:24];
        end
        lane_we = '0;
        for (int l = 0; l < LANES; l++)
        begin
            lane_wdata[l] = '0;
            lane_wrow[l]  = '0;
        end
        wp_next = wp_reg;
        if (in_acc)
        begin
            wp_next = base;
        end
        for (int j = 0; j < 3; j++)
        begin
            pos = base + LEN_W'(j);
            if (in_acc && (2'(j) < n_cand) && (pos < DEPTH_L))
            begin
                lane_we[pos[1:0]]    = 1'b1;
                lane_wdata[pos[1:0]] = cand[j];
                lane_wrow[pos[1:0]]  = pos[ROW_W+1:2];
                wp_next              = pos + LEN_W'(1);
            end
        end
        id_next  = id_reg;
        exp_next = exp_reg;
        rcv_next = rcv_reg;
        if (in_acc)
        begin
            if (is_start)
            begin
                id_next  = s_axis_tdata[15:8];
                exp_next = FIRST_FRAME + 8'(div3_7(size));
                rcv_next = FIRST_FRAME;
            end
            else
            begin
                rcv_next = rcv_reg + 8'd1;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (rcv_reg == exp_reg)
                    state_next = ST_STREAM;
                else if (out_free)
                    state_next = ST_IDLE;
            end
            ST_STREAM:
            begin
                if (out_free && (k_reg == last_k))
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE:
                ctrl.in_ready = 1'b1;
            ST_EVAL:
                ctrl.load_incomplete = (rcv_reg != exp_reg) & out_free;
            ST_STREAM:
            begin
                ctrl.load_chunk = out_free;
                ctrl.advance    = out_free & (k_reg != last_k);
            end
            default:
                ctrl = '0;
        endcase
    end

    assign s_axis_tready = ctrl.in_ready;

    assign last_k = (wp_reg == '0) ? '0 : CHUNK_W'((wp_reg - LEN_W'(1)) >> 2);

    always_comb
    begin
        if (ctrl.advance)
            k_next = k_reg + CHUNK_W'(1);
        else if (state_reg == ST_STREAM)
            k_next = ctrl.load_chunk ? '0 : k_reg;
        else
            k_next = '0;
    end

    assign rd_row = k_next[ROW_W-1:0];

    // payload store, one memory per byte lane
    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic [BYTE_W-1:0] lane_mem [ROWS];

        always_ff @(posedge clk)
        begin
            if (lane_we[l])
                lane_mem[lane_wrow[l]] <= lane_wdata[l];
            rd_data_reg[l] <= lane_mem[rd_row];
        end

        assign lane_pos[l]   = LEN_W'({k_reg, 2'(l)});
        assign chunk_byte[l] = (lane_pos[l] < wp_reg) ? rd_data_reg[l] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            id_reg        <= '0;
            exp_reg       <= '0;
            rcv_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            id_reg    <= id_next;
            exp_reg   <= exp_next;
            rcv_reg   <= rcv_next;
            k_reg     <= k_next;
            if (ctrl.load_incomplete || ctrl.load_chunk)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_incomplete)
        begin
            out_complete_reg <= 1'b0;
            out_last_reg     <= 1'b1;
            out_id_reg       <= id_reg;
            out_len_reg      <= wp_reg;
            out_chunk_reg    <= '0;
            for (int l = 0; l < LANES; l++)
                out_byte_reg[l] <= '0;
        end
        else if (ctrl.load_chunk)
        begin
            out_complete_reg <= 1'b1;
            out_last_reg     <= (k_reg == last_k);
            out_id_reg       <= id_reg;
            out_len_reg      <= wp_reg;
            out_chunk_reg    <= k_reg;
            for (int l = 0; l < LANES; l++)
                out_byte_reg[l] <= chunk_byte[l];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_complete_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {3'b000, out_byte_reg[3], out_byte_reg[2], out_byte_reg[1],
                            out_byte_reg[0], out_chunk_reg, out_len_reg, out_id_reg};

    // stored length never passes the store depth
    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= DEPTH_L)
        else $error("write position beyond store depth");

    // readback never walks past the last chunk
    a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STREAM) |-> (k_reg <= last_k))
        else $error("chunk index past message end");

    // an accepted request is always evaluated next
    a_eval_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == ST_EVAL))
        else $error("request not evaluated");

    // an incomplete status is always the only result of its request
    a_incomplete_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_complete_reg) |-> out_last_reg)
        else $error("incomplete status without last");

endmodule

>>> verif/testbench.sv
// Self-checking stream testbench for the mailbox message reassembler.
module testbench;

    import mmr_pkg::*;

    localparam int unsigned DEPTH      = 128;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam int unsigned RANDOM_ITEMS = 300;
    localparam logic        KIND_START = 1'b0;
    localparam logic        KIND_CONT  = 1'b1;

    typedef struct packed {
        logic                 complete;
        logic [BYTE_W-1:0]    id;
        logic [LEN_W-1:0]     length;
        logic [CHUNK_W-1:0]   chunk;
        logic [LANES-1:0][BYTE_W-1:0] payload;
        logic                 last;
    } chunk_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    logic [IN_DATA_W-1:0] mailboxes_pending[$];
    chunk_t               chunks_due[$];
    int                   mailboxes_total;
    int                   mailboxes_taken = 0;
    int                   errors = 0;
    int                   quiet_cycles = 0;
    int                   send_idle_pct;
    int                   recv_idle_pct;

    // shadow of the reassembly state
    logic [BYTE_W-1:0] store_shadow [DEPTH];
    logic [LEN_W-1:0]  fill_level;
    logic [BYTE_W-1:0] msg_id;
    logic [6:0]        size_declared;
    logic [7:0]        frames_due;
    logic [7:0]        frames_seen;

    mailbox_message_reassembler_unit #(.PAYLOAD_DEPTH(DEPTH)) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #5 clk = ~clk;

    always_comb
    begin
        if (mailboxes_taken < mailboxes_total / 3)
        begin
            send_idle_pct = 35;
            recv_idle_pct = 75;
        end
        else if (mailboxes_taken < 2 * mailboxes_total / 3)
        begin
            send_idle_pct = 75;
            recv_idle_pct = 35;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    function automatic logic [IN_DATA_W-1:0] mailbox_word(input logic kind, input logic [6:0] low,
                                                          input logic [7:0] b1,
                                                          input logic [7:0] b2,
                                                          input logic [7:0] b3);
        return {b3, b2, b1, kind, low};
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    function void append_byte(input logic [BYTE_W-1:0] b);
        if (fill_level < DEPTH)
        begin
            store_shadow[fill_level] = b;
            fill_level++;
        end
    endfunction

    function automatic logic [BYTE_W-1:0] stored_at(input int pos);
        return (pos < fill_level) ? store_shadow[pos] : '0;
    endfunction

    function void predict_reassembly(input logic [IN_DATA_W-1:0] word);
        logic [7:0] head;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        int         n_chunks;
        chunk_t     c;
        head = word[7:0];
        b1   = word[15:8];
        b2   = word[23:16];
        b3   = word[31:24];
        if (head[7] == KIND_START)
        begin
            size_declared = head[6:0] & SIZE_MASK;
            msg_id        = b1;
            fill_level    = '0;
            if (size_declared > 0)
                append_byte(b2);
            if (size_declared > 1)
                append_byte(b3);
            // one start frame, then ceil((size - 2) / 3) continuations
            if (size_declared <= 2)
                frames_due = 8'd1;
            else
                frames_due = 8'(1 + (int'(size_declared) - 2 + 2) / 3);
            frames_seen = FIRST_FRAME;
        end
        else
        begin
            append_byte(b1);
            append_byte(b2);
            append_byte(b3);
            frames_seen = frames_seen + 8'd1;
        end
        if (frames_seen == frames_due)
        begin
            n_chunks = (int'(fill_level) + 3) / 4;
            if (n_chunks == 0)
                n_chunks = 1;
            for (int k = 0; k < n_chunks; k++)
            begin
                c.complete = 1'b1;
                c.id       = msg_id;
                c.length   = fill_level;
                c.chunk    = CHUNK_W'(k);
                for (int j = 0; j < LANES; j++)
                    c.payload[j] = stored_at(4 * k + j);
                c.last     = (k + 1 == n_chunks);
                chunks_due.push_back(c);
            end
        end
        else
        begin
            c          = '0;
            c.id       = msg_id;
            c.length   = fill_level;
            c.last     = 1'b1;
            chunks_due.push_back(c);
        end
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // start frame plus n_cont continuations, random content
    task automatic queue_message(input int size, input int n_cont);
        mailboxes_pending.push_back(mailbox_word(KIND_START, 7'(size), rand_byte(),
                                                 rand_byte(), rand_byte()));
        repeat (n_cont)
            mailboxes_pending.push_back(mailbox_word(KIND_CONT, 7'($urandom_range(127)),
                                                     rand_byte(), rand_byte(), rand_byte()));
    endtask

    function automatic int frames_for(input int size);
        return (size <= 2) ? 1 : 1 + size / 3;
    endfunction

    // driver
    always @(posedge clk)
    begin
        logic presenting;
        if (rst_n)
        begin
            presenting = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_reassembly(mailboxes_pending.pop_front());
                mailboxes_taken++;
                presenting = 1'b0;
            end
            if (!presenting)
            begin
                if (mailboxes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= mailboxes_pending[0];
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        chunk_t got;
        chunk_t want;
        if (rst_n)
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.complete = m_axis_tuser;
                got.id       = m_axis_tdata[7:0];
                got.length   = m_axis_tdata[15:8];
                got.chunk    = m_axis_tdata[20:16];
                got.payload  = {m_axis_tdata[52:45], m_axis_tdata[44:37],
                                m_axis_tdata[36:29], m_axis_tdata[28:21]};
                got.last     = m_axis_tlast;
                if (chunks_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                    errors++;
                end
                else
                begin
                    want = chunks_due.pop_front();
                    check_field("complete", 8'(want.complete), 8'(got.complete));
                    check_field("message_id", want.id, got.id);
                    check_field("message_length", want.length, got.length);
                    check_field("chunk_number", 8'(want.chunk), 8'(got.chunk));
                    check_field("chunk_byte_a", want.payload[0], got.payload[0]);
                    check_field("chunk_byte_b", want.payload[1], got.payload[1]);
                    check_field("chunk_byte_c", want.payload[2], got.payload[2]);
                    check_field("chunk_byte_d", want.payload[3], got.payload[3]);
                    check_field("last", 8'(want.last), 8'(got.last));
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int size;
        int pick;
        int frames;
        fill_level    = '0;
        msg_id        = '0;
        size_declared = '0;
        frames_due    = '0;
        frames_seen   = '0;
        foreach (store_shadow[i])
            store_shadow[i] = '0;

        // continuation straight after reset: no start seen yet
        mailboxes_pending.push_back(mailbox_word(KIND_CONT, 7'h7F, 8'hFF, 8'h00, 8'hFF));
        mailboxes_pending.push_back(mailbox_word(KIND_CONT, 7'h00, 8'h00, 8'hFF, 8'h00));
        // empty message, one and two byte messages
        mailboxes_pending.push_back(mailbox_word(KIND_START, 7'd0, 8'h00, 8'hAA, 8'h55));
        mailboxes_pending.push_back(mailbox_word(KIND_START, 7'd1, 8'hFF, 8'hAA, 8'h55));
        mailboxes_pending.push_back(mailbox_word(KIND_START, 7'd2, 8'h5A, 8'hFF, 8'h00));
        // two frames, then a surplus continuation
        mailboxes_pending.push_back(mailbox_word(KIND_START, 7'd3, 8'hA5, 8'h01, 8'h02));
        mailboxes_pending.push_back(mailbox_word(KIND_CONT, 7'h55, 8'h03, 8'h04, 8'h05));
        mailboxes_pending.push_back(mailbox_word(KIND_CONT, 7'h2A, 8'h06, 8'h07, 8'h08));
        // exact chunk multiple, and a size that leaves extra bytes stored
        queue_message(8, 2);
        queue_message(6, 2);
        // truncated by a fresh start
        queue_message(20, 2);
        queue_message(4, 1);
        // largest declared size, store fills up
        queue_message(127, frames_for(127) - 1);

        while (mailboxes_pending.size() < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            size = ($urandom_range(99) < 85) ? $urandom_range(24) : $urandom_range(127, 25);
            frames = frames_for(size);
            if (pick < 70)
                queue_message(size, frames - 1);
            else if (pick < 85)
            begin
                if ($urandom_range(1) == 0)
                    queue_message(size, $urandom_range(frames - 1));
                else
                    queue_message(size, frames + $urandom_range(2));
            end
            else
                mailboxes_pending.push_back($urandom());
        end

        mailboxes_total = mailboxes_pending.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (mailboxes_pending.size() != 0 || chunks_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/mmr_pkg.sv
rtl/core/mailbox_message_reassembler_unit.sv
verif/testbench.sv
